>>> hdl/mlit_pkg.sv
// ----------------------------------------------------------------------------
// mlit_pkg
// Shared types, codes and helpers for the mesh interpolation/integration block.
// ----------------------------------------------------------------------------
package mlit_pkg;

    typedef enum logic [1:0] {
        OP_WR_COORD = 2'd0,
        OP_WR_VAR   = 2'd1,
        OP_INTERP   = 2'd2,
        OP_INTEG    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_BAD_VAR = 2'd2
    } status_t;

    typedef enum logic {
        CFG_NODE_COUNT = 1'b0,
        CFG_EDGE_TOL   = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_VRD_L,
        S_VRD_R,
        S_VCAP,
        S_VMUL,
        S_VDIV,
        S_IRD,
        S_ICAP,
        S_IMUL,
        S_EMIT
    } state_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    localparam int MAG_W  = 33;
    localparam int PROD_W = 65;
    localparam int ACC_W  = 74;
    localparam int RES_W  = 48;
    localparam int WIDE_W = 57;

    localparam logic [PROD_W-1:0] Q_LIMIT = PROD_W'(1) << RES_W;
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    function automatic logic [MAG_W-1:0] mag33(input logic signed [MAG_W-1:0] v);
        mag33 = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(RES_MAX);
        lo = WIDE_W'(RES_MIN);
        if (v > hi) begin
            sat_res = RES_MAX;
        end else if (v < lo) begin
            sat_res = RES_MIN;
        end else begin
            sat_res = v[RES_W-1:0];
        end
    endfunction

endpackage

>>> hdl/mlit_ram.sv
// ----------------------------------------------------------------------------
// mlit_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mlit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mlit_alu.sv
// ----------------------------------------------------------------------------
// mlit_alu
// Shared multi-cycle unit: 33x33 unsigned multiply in two 33x17 steps, or
// 65/33 unsigned restoring divide at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlit_alu (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlit_pkg::alu_req_t            req,
    input  logic [mlit_pkg::PROD_W-1:0]   opa,
    input  logic [mlit_pkg::MAG_W-1:0]    opb,
    output logic                          done,
    output logic [mlit_pkg::PROD_W-1:0]   res
);

    localparam int CW = $clog2(mlit_pkg::PROD_W);

    logic                          busy_reg;
    logic                          done_reg;
    mlit_pkg::alu_op_t             op_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [mlit_pkg::MAG_W-1:0]    a_reg;
    logic [mlit_pkg::MAG_W-1:0]    b_reg;
    logic [mlit_pkg::MAG_W-1:0]    rem_reg;
    logic [mlit_pkg::PROD_W-1:0]   res_reg;

    logic [16:0]                   mul_b;
    logic [49:0]                   pp;
    logic [mlit_pkg::MAG_W:0]      trial;

    assign mul_b = cnt_reg[0] ? {1'b0, b_reg[32:17]} : b_reg[16:0];
    assign pp    = 50'(a_reg) * 50'(mul_b);
    assign trial = {rem_reg, res_reg[mlit_pkg::PROD_W-1]} - {1'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if ((op_reg == mlit_pkg::ALU_MUL && cnt_reg == CW'(1)) ||
                    (op_reg == mlit_pkg::ALU_DIV && cnt_reg == CW'(mlit_pkg::PROD_W-1))) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg  <= req.op;
            cnt_reg <= '0;
            a_reg   <= opa[mlit_pkg::MAG_W-1:0];
            b_reg   <= opb;
            rem_reg <= '0;
            res_reg <= (req.op == mlit_pkg::ALU_DIV) ? opa : '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (op_reg == mlit_pkg::ALU_MUL) begin
                if (cnt_reg[0]) begin
                    res_reg <= res_reg + (mlit_pkg::PROD_W'(pp) << 17);
                end else begin
                    res_reg <= mlit_pkg::PROD_W'(pp);
                end
            end else begin
                if (!trial[mlit_pkg::MAG_W]) begin
                    rem_reg <= trial[mlit_pkg::MAG_W-1:0];
                end else begin
                    rem_reg <= {rem_reg[mlit_pkg::MAG_W-2:0], res_reg[mlit_pkg::PROD_W-1]};
                end
                res_reg <= {res_reg[mlit_pkg::PROD_W-2:0], ~trial[mlit_pkg::MAG_W]};
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> hdl/mesh_linear_interp_trapezoid_top.sv
// ----------------------------------------------------------------------------
// mesh_linear_interp_trapezoid_top
// 1-D mesh store with piecewise linear interpolation and trapezoidal integral.
// ----------------------------------------------------------------------------
// Input words on s_* carry an operation: write a node coordinate, write a
// node variable, interpolate at a position, or integrate one variable.
// Registers node_count and edge_tolerance are written on the cfg_* channel
// (always ready); the user must write them only while the block is idle;
// the block itself does not enforce this. Writes give no output word. An
// interpolation scans the coordinate RAM one node per cycle, then per
// variable uses the shared multiply/divide unit (two multiply steps plus a
// 65-step divider) when the segment has non-zero width. An integration
// walks every node in use, bounded by the shared multiplier. s_tready is
// high only when idle. Results go to an output register; the sequencer
// waits there when m_tready is low, and the last word of an item may still
// wait while a new item is taken. Reset (aresetn low, synchronous) resets
// control state and the registers (node_count to 2, edge_tolerance to 0);
// the mesh RAMs are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module mesh_linear_interp_trapezoid_top #(
    parameter int MAX_NODES = 256,
    parameter int NUM_VARS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], node_index[9:2], var_index[12:10], position[44:13],
    // value[76:45], zero pad[79:77]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_value[47:0], result_var[50:48], zero pad[55:51]
    output logic [55:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int VA = $clog2(MAX_NODES * NUM_VARS);
    localparam int MW = mlit_pkg::MAG_W;
    localparam int PW = mlit_pkg::PROD_W;
    localparam int RW = mlit_pkg::RES_W;

    mlit_pkg::state_t state_reg, state_next;

    logic [8:0]  node_count_reg;
    logic [15:0] tol_reg;

    mlit_pkg::op_t      in_op;
    logic [7:0]         in_node;
    logic [2:0]         in_var;
    logic signed [31:0] in_pos;
    logic [31:0]        in_val;
    logic               s_accept;
    logic               node_ok;
    logic               var_ok;
    logic [NW-1:0]      n_use;

    logic               coord_we;
    logic [AW-1:0]      coord_addr;
    logic [31:0]        coord_rdata;
    logic               var_we;
    logic [VA-1:0]      var_addr;
    logic [31:0]        var_rdata;

    mlit_pkg::alu_req_t alu_req;
    logic [PW-1:0]      alu_opa;
    logic [MW-1:0]      alu_opb;
    logic               alu_done;
    logic [PW-1:0]      alu_res;

    logic signed [31:0] p_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] l_reg;
    logic signed [31:0] xp_reg;
    logic signed [31:0] yp_reg;
    logic [NW-1:0]      j_reg;
    logic               pend_reg;
    logic               first_reg;
    logic [AW-1:0]      left_reg;
    logic [2:0]         vi_reg;
    logic [2:0]         var_reg;
    logic               neg_reg;
    logic signed [mlit_pkg::ACC_W-1:0] acc_reg;

    logic signed [RW-1:0] stg_val_reg;
    logic [2:0]           stg_var_reg;
    mlit_pkg::status_t    stg_st_reg;
    logic                 stg_last_reg;
    logic                 more_reg;

    logic                 m_valid_reg;
    logic signed [RW-1:0] m_val_reg;
    logic [2:0]           m_var_reg;
    mlit_pkg::status_t    m_st_reg;
    logic                 m_last_reg;
    logic                 out_free;
    logic                 out_load;

    logic signed [31:0]   x_rd;
    logic signed [31:0]   y_rd;
    logic signed [MW-1:0] near_a_d;
    logic signed [MW-1:0] near_x_d;
    logic                 scan_hit;
    logic                 scan_cmp;
    logic [NW-1:0]        left_calc;
    logic [AW-1:0]        left_p1;
    logic signed [MW-1:0] d_w;
    logic signed [MW-1:0] w_w;
    logic signed [MW-1:0] dv_w;
    logic signed [MW-1:0] dx_w;
    logic signed [MW-1:0] s_w;
    logic [PW-1:0]        q_c;
    logic signed [49:0]   interp_sum;
    logic signed [mlit_pkg::ACC_W-1:0] acc_sum;
    logic                 last_var;

    assign in_op    = mlit_pkg::op_t'(s_tdata[1:0]);
    assign in_node  = s_tdata[9:2];
    assign in_var   = s_tdata[12:10];
    assign in_pos   = s_tdata[44:13];
    assign in_val   = s_tdata[76:45];
    assign s_tready = (state_reg == mlit_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign node_ok  = 32'(in_node) < MAX_NODES;
    assign var_ok   = 32'(in_var) < NUM_VARS;

    always_comb begin
        if (node_count_reg < 9'd2) begin
            n_use = NW'(2);
        end else if (32'(node_count_reg) > MAX_NODES) begin
            n_use = NW'(MAX_NODES);
        end else begin
            n_use = NW'(node_count_reg);
        end
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 9'd2;
            tol_reg        <= '0;
        end else if (cfg_valid) begin
            unique case (mlit_pkg::cfg_idx_t'(cfg_index))
                mlit_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[8:0];
                mlit_pkg::CFG_EDGE_TOL:   tol_reg        <= cfg_data;
                default:                  node_count_reg <= node_count_reg;
            endcase
        end
    end

    mlit_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_coord_ram (
        .aclk  (aclk),
        .we    (coord_we),
        .addr  (coord_addr),
        .wdata (in_pos),
        .rdata (coord_rdata)
    );

    mlit_ram #(.WIDTH(32), .DEPTH(MAX_NODES * NUM_VARS)) u_var_ram (
        .aclk  (aclk),
        .we    (var_we),
        .addr  (var_addr),
        .wdata (in_val),
        .rdata (var_rdata)
    );

    mlit_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .done    (alu_done),
        .res     (alu_res)
    );

    // datapath arithmetic
    assign x_rd      = coord_rdata;
    assign y_rd      = var_rdata;
    assign near_a_d  = MW'(a_reg) - MW'(p_reg);
    assign near_x_d  = MW'(x_rd) - MW'(p_reg);
    assign scan_hit  = (a_reg < p_reg && x_rd > p_reg) ||
                       (mlit_pkg::mag33(near_a_d) <= {17'd0, tol_reg}) ||
                       (mlit_pkg::mag33(near_x_d) <= {17'd0, tol_reg});
    assign scan_cmp  = pend_reg && !first_reg;
    assign left_calc = j_reg - NW'(2);
    assign left_p1   = left_reg + AW'(1);
    assign d_w       = MW'(p_reg) - MW'(a_reg);
    assign w_w       = MW'(b_reg) - MW'(a_reg);
    assign dv_w      = MW'(y_rd) - MW'(l_reg);
    assign dx_w      = MW'(x_rd) - MW'(xp_reg);
    assign s_w       = MW'(y_rd) + MW'(yp_reg);
    assign q_c       = (alu_res > mlit_pkg::Q_LIMIT) ? mlit_pkg::Q_LIMIT : alu_res;
    assign interp_sum = neg_reg ? (50'(l_reg) - $signed(50'(q_c)))
                                : (50'(l_reg) + $signed(50'(q_c)));
    assign acc_sum   = neg_reg ? (acc_reg - $signed(mlit_pkg::ACC_W'(alu_res)))
                               : (acc_reg + $signed(mlit_pkg::ACC_W'(alu_res)));
    assign last_var  = (32'(vi_reg) == NUM_VARS - 1);
    assign out_free  = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlit_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (in_op == mlit_pkg::OP_INTERP) begin
                        state_next = mlit_pkg::S_SCAN;
                    end else if (in_op == mlit_pkg::OP_INTEG) begin
                        state_next = var_ok ? mlit_pkg::S_IRD : mlit_pkg::S_EMIT;
                    end
                end
            end
            mlit_pkg::S_SCAN: begin
                if (scan_cmp && scan_hit) begin
                    state_next = mlit_pkg::S_VRD_L;
                end else if (scan_cmp && j_reg == n_use) begin
                    state_next = mlit_pkg::S_EMIT;
                end
            end
            mlit_pkg::S_VRD_L: state_next = mlit_pkg::S_VRD_R;
            mlit_pkg::S_VRD_R: state_next = mlit_pkg::S_VCAP;
            mlit_pkg::S_VCAP: begin
                state_next = (w_w == '0) ? mlit_pkg::S_EMIT : mlit_pkg::S_VMUL;
            end
            mlit_pkg::S_VMUL: begin
                if (alu_done) state_next = mlit_pkg::S_VDIV;
            end
            mlit_pkg::S_VDIV: begin
                if (alu_done) state_next = mlit_pkg::S_EMIT;
            end
            mlit_pkg::S_IRD: state_next = mlit_pkg::S_ICAP;
            mlit_pkg::S_ICAP: begin
                state_next = (j_reg == '0) ? mlit_pkg::S_IRD : mlit_pkg::S_IMUL;
            end
            mlit_pkg::S_IMUL: begin
                if (alu_done) begin
                    state_next = (j_reg == n_use - NW'(1)) ? mlit_pkg::S_EMIT
                                                           : mlit_pkg::S_IRD;
                end
            end
            mlit_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = more_reg ? mlit_pkg::S_VRD_L : mlit_pkg::S_IDLE;
                end
            end
            default: state_next = mlit_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        coord_we   = 1'b0;
        var_we     = 1'b0;
        coord_addr = j_reg[AW-1:0];
        var_addr   = VA'(j_reg[AW-1:0]) * VA'(NUM_VARS) + VA'(var_reg);
        alu_req    = '{start: 1'b0, op: mlit_pkg::ALU_MUL};
        alu_opa    = PW'(mlit_pkg::mag33(dv_w));
        alu_opb    = mlit_pkg::mag33(d_w);
        out_load   = 1'b0;
        unique case (state_reg)
            mlit_pkg::S_IDLE: begin
                coord_addr = AW'(in_node);
                var_addr   = VA'(in_node) * VA'(NUM_VARS) + VA'(in_var);
                coord_we   = s_accept && in_op == mlit_pkg::OP_WR_COORD && node_ok;
                var_we     = s_accept && in_op == mlit_pkg::OP_WR_VAR && node_ok && var_ok;
            end
            mlit_pkg::S_VRD_L: begin
                var_addr = VA'(left_reg) * VA'(NUM_VARS) + VA'(vi_reg);
            end
            mlit_pkg::S_VRD_R: begin
                var_addr = VA'(left_p1) * VA'(NUM_VARS) + VA'(vi_reg);
            end
            mlit_pkg::S_VCAP: begin
                alu_req.start = (w_w != '0);
            end
            mlit_pkg::S_VMUL: begin
                alu_req = '{start: alu_done, op: mlit_pkg::ALU_DIV};
                alu_opa = alu_res;
                alu_opb = mlit_pkg::mag33(w_w);
            end
            mlit_pkg::S_ICAP: begin
                alu_req.start = (j_reg != '0);
                alu_opa       = PW'(mlit_pkg::mag33(dx_w));
                alu_opb       = mlit_pkg::mag33(s_w);
            end
            mlit_pkg::S_EMIT: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlit_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            mlit_pkg::S_IDLE: begin
                p_reg     <= in_pos;
                var_reg   <= in_var;
                j_reg     <= '0;
                pend_reg  <= 1'b0;
                first_reg <= 1'b1;
                vi_reg    <= '0;
                acc_reg   <= '0;
                stg_val_reg  <= '0;
                stg_var_reg  <= in_var;
                stg_st_reg   <= mlit_pkg::STAT_BAD_VAR;
                stg_last_reg <= 1'b1;
                more_reg     <= 1'b0;
            end
            mlit_pkg::S_SCAN: begin
                j_reg    <= j_reg + NW'(1);
                pend_reg <= 1'b1;
                if (pend_reg) begin
                    first_reg <= 1'b0;
                    a_reg     <= x_rd;
                end
                if (scan_cmp && scan_hit) begin
                    a_reg    <= a_reg;
                    b_reg    <= x_rd;
                    left_reg <= left_calc[AW-1:0];
                end
                stg_val_reg  <= '0;
                stg_var_reg  <= '0;
                stg_st_reg   <= mlit_pkg::STAT_RANGE;
                stg_last_reg <= 1'b1;
                more_reg     <= 1'b0;
            end
            mlit_pkg::S_VRD_R: begin
                l_reg <= y_rd;
            end
            mlit_pkg::S_VCAP: begin
                neg_reg      <= dv_w[MW-1] ^ d_w[MW-1] ^ w_w[MW-1];
                stg_val_reg  <= RW'(l_reg);
                stg_var_reg  <= vi_reg;
                stg_st_reg   <= mlit_pkg::STAT_OK;
                stg_last_reg <= last_var;
                more_reg     <= !last_var;
            end
            mlit_pkg::S_VDIV: begin
                if (alu_done) begin
                    stg_val_reg <= mlit_pkg::sat_res(mlit_pkg::WIDE_W'(interp_sum));
                end
            end
            mlit_pkg::S_ICAP: begin
                xp_reg  <= x_rd;
                yp_reg  <= y_rd;
                neg_reg <= dx_w[MW-1] ^ s_w[MW-1];
                if (j_reg == '0) begin
                    j_reg <= j_reg + NW'(1);
                end
            end
            mlit_pkg::S_IMUL: begin
                if (alu_done) begin
                    acc_reg      <= acc_sum;
                    j_reg        <= j_reg + NW'(1);
                    stg_val_reg  <= mlit_pkg::sat_res(acc_sum[mlit_pkg::ACC_W-1:17]);
                    stg_var_reg  <= var_reg;
                    stg_st_reg   <= mlit_pkg::STAT_OK;
                    stg_last_reg <= 1'b1;
                    more_reg     <= 1'b0;
                end
            end
            mlit_pkg::S_EMIT: begin
                if (out_free) begin
                    vi_reg <= vi_reg + 3'd1;
                end
            end
            default: begin
                more_reg <= more_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_val_reg  <= stg_val_reg;
            m_var_reg  <= stg_var_reg;
            m_st_reg   <= stg_st_reg;
            m_last_reg <= stg_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_var_reg, m_val_reg};
    assign m_tuser  = m_st_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> tb/tb_mesh_linear_interp_trapezoid_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_linear_interp_trapezoid_top
// Self-checking bench for the mesh interpolation and trapezoid integral block.
// Loads a full mesh, runs directed edge cases, then random operations at
// several node counts and tolerances with random stalls on both streams and
// one long output hold-off. Every output word is checked against a local
// model of the mesh.
// ----------------------------------------------------------------------------
module tb_mesh_linear_interp_trapezoid_top;
    import mlit_pkg::*;

    localparam int NODES = 256;
    localparam int VARS  = 4;
    localparam longint LIM47 = 64'sd140737488355328;

    typedef struct {
        logic [47:0] value;
        logic [2:0]  vidx;
        status_t     st;
        logic        last;
    } mesh_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    mesh_linear_interp_trapezoid_top #(.MAX_NODES(NODES), .NUM_VARS(VARS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mesh model
    logic signed [31:0] mesh_x [NODES];
    logic signed [31:0] mesh_v [NODES][VARS];
    logic [8:0]  node_count_reg = 9'd2;
    logic [15:0] edge_tol_reg = 16'd0;

    mesh_result_t expected_q[$];
    int  mismatches = 0;
    int  words_checked = 0;
    int  items_sent = 0;
    bit  idle_en = 1'b1;
    bit  hold_req = 1'b0;

    function automatic int nodes_in_use();
        if (node_count_reg < 2) return 2;
        if (node_count_reg > NODES) return NODES;
        return node_count_reg;
    endfunction

    function automatic longint sat48(longint v);
        if (v >= LIM47) return LIM47 - 1;
        if (v < -LIM47) return -LIM47;
        return v;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void push_result(longint val, logic [2:0] vi, status_t st, logic lst);
        mesh_result_t r;
        r.value = val[47:0];
        r.vidx = vi;
        r.st = st;
        r.last = lst;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_interp(logic signed [31:0] pos);
        int n;
        longint p, a, b, tol, d, w, l, r, dv, res;
        logic [127:0] prod, q;
        bit neg;
        n = nodes_in_use();
        p = pos;
        tol = edge_tol_reg;
        for (int i = 0; i + 1 < n; i++) begin
            a = mesh_x[i];
            b = mesh_x[i+1];
            if ((a < p && b > p) || absl(a - p) <= tol || absl(b - p) <= tol) begin
                d = p - a;
                w = b - a;
                for (int v = 0; v < VARS; v++) begin
                    l = mesh_v[i][v];
                    r = mesh_v[i+1][v];
                    res = l;
                    if (w != 0) begin
                        dv = r - l;
                        prod = 128'(absl(dv)) * 128'(absl(d));
                        q = prod / 128'(absl(w));
                        if (q > 128'(2 * LIM47)) q = 128'(2 * LIM47);
                        neg = ((dv < 0) != (d < 0)) != (w < 0);
                        res = neg ? l - longint'(q) : l + longint'(q);
                    end
                    push_result(sat48(res), 3'(v), STAT_OK, v == VARS - 1);
                end
                return;
            end
        end
        push_result(0, 3'd0, STAT_RANGE, 1'b1);
    endfunction

    function automatic longint trapezoid_sum(int v);
        logic signed [127:0] acc;
        logic signed [127:0] dx, s, lim;
        acc = '0;
        lim = 128'sd1 <<< 64;
        for (int i = 0; i + 1 < nodes_in_use(); i++) begin
            dx = 128'(longint'(mesh_x[i+1]) - longint'(mesh_x[i]));
            s = 128'(longint'(mesh_v[i][v]) + longint'(mesh_v[i+1][v]));
            acc = acc + dx * s;
        end
        if (acc >= lim) return LIM47 - 1;
        if (acc < -lim) return -LIM47;
        acc = acc >>> 17;
        return longint'(acc[63:0]);
    endfunction

    function automatic void predict_word(op_t op, logic [7:0] node, logic [2:0] vi,
                                         logic [31:0] pos, logic [31:0] val);
        case (op)
            OP_WR_COORD: mesh_x[node] = pos;
            OP_WR_VAR: if (vi < VARS) mesh_v[node][vi] = val;
            OP_INTERP: predict_interp(pos);
            default: begin
                if (vi >= VARS) push_result(0, vi, STAT_BAD_VAR, 1'b1);
                else push_result(trapezoid_sum(vi), vi, STAT_OK, 1'b1);
            end
        endcase
    endfunction

    task automatic send_word(op_t op, logic [7:0] node, logic [2:0] vi,
                             logic [31:0] pos, logic [31:0] val);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, val, pos, vi, node, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(op, node, vi, pos, val);
        items_sent++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_NODE_COUNT) node_count_reg = data[8:0];
        else edge_tol_reg = data;
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        mesh_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h user %h last %b",
                                               m_tdata, m_tuser, m_tlast);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[47:0] !== e.value || m_tdata[50:48] !== e.vidx ||
                    m_tuser !== e.st || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val %h var %0d st %0d last %b, got %h %0d %0d %b",
                                 e.value, e.vidx, e.st, e.last, m_tdata[47:0],
                                 m_tdata[50:48], m_tuser, m_tlast);
                end
            end
        end
    end

    // output side stalls and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic load_mesh();
        longint x;
        for (int i = 0; i < NODES; i++) begin
            x = -64'sd2147483648 + longint'(i) * 64'sd16777216 + $urandom_range(0, 4000000);
            if (i == NODES - 1) x = 64'sd2147483647;
            send_word(OP_WR_COORD, 8'(i), 3'd0, 32'(x), 32'd0);
        end
        for (int i = 0; i < NODES; i++)
            for (int v = 0; v < VARS; v++)
                send_word(OP_WR_VAR, 8'(i), 3'(v), $urandom, $urandom);
    endtask

    task automatic test_directed_edges();
        write_reg(CFG_NODE_COUNT, 16'd0);
        write_reg(CFG_EDGE_TOL, 16'd0);
        send_word(OP_WR_COORD, 8'd0, 3'd0, 32'h8000_0000, 32'd0);
        send_word(OP_WR_COORD, 8'd1, 3'd0, 32'h7fff_ffff, 32'd0);
        send_word(OP_WR_VAR, 8'd0, 3'd0, 32'd0, 32'h8000_0000);
        send_word(OP_WR_VAR, 8'd1, 3'd0, 32'hffff_ffff, 32'h7fff_ffff);
        send_word(OP_WR_VAR, 8'd1, 3'd5, 32'd0, 32'h1234_5678);
        send_word(OP_INTERP, 8'hff, 3'd7, 32'h8000_0000, 32'hffff_ffff);
        send_word(OP_INTERP, 8'd0, 3'd0, 32'h7fff_ffff, 32'd0);
        send_word(OP_INTERP, 8'd0, 3'd0, 32'd0, 32'd0);
        send_word(OP_INTEG, 8'd0, 3'd0, 32'd0, 32'd0);
        send_word(OP_INTEG, 8'd0, 3'd7, 32'd0, 32'd0);
        write_reg(CFG_EDGE_TOL, 16'hffff);
        send_word(OP_WR_COORD, 8'd0, 3'd0, 32'd0, 32'd0);
        send_word(OP_WR_COORD, 8'd1, 3'd0, 32'd1, 32'd0);
        send_word(OP_INTERP, 8'd0, 3'd0, 32'd65536, 32'd0);
        send_word(OP_INTERP, 8'd0, 3'd0, -32'sd65535, 32'd0);
        send_word(OP_INTERP, 8'd0, 3'd0, 32'd70000, 32'd0);
        send_word(OP_WR_COORD, 8'd1, 3'd0, 32'd0, 32'd0);
        send_word(OP_INTERP, 8'd0, 3'd0, 32'd0, 32'd0);
        send_word(OP_INTEG, 8'd0, 3'd1, 32'd0, 32'd0);
        write_reg(CFG_EDGE_TOL, 16'd0);
        send_word(OP_INTERP, 8'd0, 3'd0, 32'd5, 32'd0);
    endtask

    task automatic random_word(int span);
        int sel, k;
        longint pos, lo, hi;
        logic [7:0] node;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, span - 2);
        node = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, span - 1)) : 8'($urandom);
        if (sel < 12) begin
            lo = mesh_x[k];
            pos = ($urandom_range(0, 3) == 0) ? longint'($signed($urandom))
                                              : lo + $urandom_range(0, 65536);
            send_word(OP_WR_COORD, node, 3'($urandom), 32'(pos), $urandom);
        end else if (sel < 25) begin
            send_word(OP_WR_VAR, node, 3'($urandom), $urandom, $urandom);
        end else if (sel < 65) begin
            lo = mesh_x[k];
            hi = mesh_x[k+1];
            case ($urandom_range(0, 3))
                0: pos = longint'($signed($urandom));
                1: pos = lo + longint'($urandom_range(0, 2 * edge_tol_reg + 2))
                         - edge_tol_reg - 1;
                default: pos = (lo < hi) ? lo + longint'($urandom_range(0, 32'(hi - lo)))
                                         : lo;
            endcase
            send_word(OP_INTERP, 8'($urandom), 3'($urandom), 32'(pos), $urandom);
        end else begin
            send_word(OP_INTEG, 8'($urandom), 3'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                                      : $urandom_range(0, 7)),
                      $urandom, $urandom);
        end
    endtask

    task automatic test_random_mid();
        write_reg(CFG_NODE_COUNT, 16'd8);
        write_reg(CFG_EDGE_TOL, 16'd300);
        repeat (50) random_word(8);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (10) random_word(8);
    endtask

    task automatic test_random_two_nodes();
        write_reg(CFG_NODE_COUNT, 16'd1);
        write_reg(CFG_EDGE_TOL, 16'hffff);
        repeat (30) random_word(2);
    endtask

    task automatic test_full_mesh();
        write_reg(CFG_NODE_COUNT, 16'hffff);
        write_reg(CFG_EDGE_TOL, 16'd0);
        repeat (10) random_word(NODES);
    endtask

    task automatic test_random_no_idle();
        write_reg(CFG_NODE_COUNT, 16'd16);
        write_reg(CFG_EDGE_TOL, 16'd1000);
        idle_en = 1'b0;
        repeat (60) random_word(16);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_mesh();
        test_directed_edges();
        test_random_mid();
        test_backpressure();
        test_random_two_nodes();
        test_full_mesh();
        test_random_no_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("sent %0d words (mesh load, edge cases, random ops at 2..256 nodes)",
                 items_sent);
        $display("checked %0d output words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("mesh_linear_interp_trapezoid_top verification clean");
        end else begin
            $display("mesh_linear_interp_trapezoid_top verification failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("mesh_linear_interp_trapezoid_top verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/mlit_pkg.sv
hdl/mlit_ram.sv
hdl/mlit_alu.sv
hdl/mesh_linear_interp_trapezoid_top.sv
tb/tb_mesh_linear_interp_trapezoid_top.sv
